### design/jsu_pkg.sv
package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_ESCAPE = 3'b010,
        MODE_HEX    = 3'b100
    } mode_t;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_UNTERM = 2'd2;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);
    localparam int PEND_DEPTH  = 3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [15:0] UTF8_LIM1  = 16'h0080;
    localparam logic [15:0] UTF8_LIM2  = 16'h0800;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  hex_count;
        logic [15:0] code;
        logic        frozen;
    } dec_state_t;

    localparam dec_state_t DEC_STATE_RESET = '{
        mode:      MODE_NORMAL,
        hex_count: 2'd0,
        code:      16'd0,
        frozen:    1'b0
    };

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
    } result_t;

    typedef struct packed {
        logic       we;
        logic [1:0] idx;
        logic [7:0] data;
    } pend_wr_t;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66)
            r = {1'b1, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46)
            r = {1'b1, 4'(b - 8'h37)};
        return r;
    endfunction

endpackage

### design/jsu_decode.sv
module jsu_decode
(
    input  jsu_pkg::dec_state_t            st,
    input  logic [7:0]                     pend [jsu_pkg::PEND_DEPTH],
    input  logic [7:0]                     in_byte,
    input  logic                           in_last,
    output jsu_pkg::dec_state_t            st_next,
    output jsu_pkg::pend_wr_t              pend_wr,
    output jsu_pkg::result_t               res [jsu_pkg::MAX_RESULTS],
    output logic [jsu_pkg::CNT_W-1:0]      res_cnt
);

    logic [4:0]                hd;
    logic [15:0]               cp;
    logic                      closed;
    logic [jsu_pkg::CNT_W-1:0] cnt;

    assign hd = jsu_pkg::hex_digit(in_byte);

    always_comb
    begin
        st_next = st;
        pend_wr = '0;
        closed  = 1'b0;
        cnt     = '0;
        cp      = st.code;
        for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++)
        begin
            res[i] = '0;
        end

        case (st.mode)
            jsu_pkg::MODE_ESCAPE:
            begin
                st_next.mode = jsu_pkg::MODE_NORMAL;
                case (in_byte)
                    jsu_pkg::CH_N:
                    begin
                        res[0] = '{data: jsu_pkg::CH_LF, kind: jsu_pkg::KIND_DATA};
                        cnt = 3'd1;
                    end
                    jsu_pkg::CH_T:
                    begin
                        res[0] = '{data: jsu_pkg::CH_TAB, kind: jsu_pkg::KIND_DATA};
                        cnt = 3'd1;
                    end
                    jsu_pkg::CH_R:
                    begin
                        res[0] = '{data: jsu_pkg::CH_CR, kind: jsu_pkg::KIND_DATA};
                        cnt = 3'd1;
                    end
                    jsu_pkg::CH_U:
                    begin
                        st_next.mode      = jsu_pkg::MODE_HEX;
                        st_next.hex_count = 2'd0;
                        st_next.code      = 16'd0;
                        st_next.frozen    = 1'b0;
                    end
                    default:
                    begin
                        res[0] = '{data: in_byte, kind: jsu_pkg::KIND_DATA};
                        cnt = 3'd1;
                    end
                endcase
            end

            jsu_pkg::MODE_HEX:
            begin
                // stop taking digits at the first non-hex byte
                if (!st.frozen && hd[4])
                    cp = {st.code[11:0], hd[3:0]};
                else
                    st_next.frozen = 1'b1;
                st_next.code = cp;

                if (st.hex_count == 2'd3)
                begin
                    st_next.mode      = jsu_pkg::MODE_NORMAL;
                    st_next.hex_count = 2'd0;
                    if (cp < jsu_pkg::UTF8_LIM1)
                    begin
                        res[0] = '{data: cp[7:0], kind: jsu_pkg::KIND_DATA};
                        cnt = 3'd1;
                    end
                    else if (cp < jsu_pkg::UTF8_LIM2)
                    begin
                        res[0] = '{data: jsu_pkg::UTF8_LEAD2 | {3'd0, cp[10:6]},
                                   kind: jsu_pkg::KIND_DATA};
                        res[1] = '{data: jsu_pkg::UTF8_CONT | {2'd0, cp[5:0]},
                                   kind: jsu_pkg::KIND_DATA};
                        cnt = 3'd2;
                    end
                    else
                    begin
                        res[0] = '{data: jsu_pkg::UTF8_LEAD3 | {4'd0, cp[15:12]},
                                   kind: jsu_pkg::KIND_DATA};
                        res[1] = '{data: jsu_pkg::UTF8_CONT | {2'd0, cp[11:6]},
                                   kind: jsu_pkg::KIND_DATA};
                        res[2] = '{data: jsu_pkg::UTF8_CONT | {2'd0, cp[5:0]},
                                   kind: jsu_pkg::KIND_DATA};
                        cnt = 3'd3;
                    end
                end
                else if (in_last)
                begin
                    // short \u at end of input: replay the collected bytes literally
                    for (int i = 0; i < jsu_pkg::PEND_DEPTH; i++)
                    begin
                        if (2'(i) < st.hex_count)
                        begin
                            res[i] = '{data: pend[i], kind: jsu_pkg::KIND_DATA};
                        end
                    end
                    res[st.hex_count] = '{data: in_byte, kind: jsu_pkg::KIND_DATA};
                    cnt = {1'b0, st.hex_count} + 3'd1;
                end
                else
                begin
                    pend_wr.we        = 1'b1;
                    pend_wr.idx       = st.hex_count;
                    pend_wr.data      = in_byte;
                    st_next.hex_count = st.hex_count + 2'd1;
                end
            end

            default:
            begin
                if (in_byte == jsu_pkg::CH_QUOTE)
                begin
                    res[0] = '{data: 8'd0, kind: jsu_pkg::KIND_CLOSED};
                    cnt    = 3'd1;
                    closed = 1'b1;
                end
                else if (in_byte == jsu_pkg::CH_BSLASH)
                begin
                    st_next.mode = jsu_pkg::MODE_ESCAPE;
                end
                else
                begin
                    res[0] = '{data: in_byte, kind: jsu_pkg::KIND_DATA};
                    cnt = 3'd1;
                end
            end
        endcase

        if (closed)
        begin
            st_next = jsu_pkg::DEC_STATE_RESET;
        end
        else if (in_last)
        begin
            res[cnt[jsu_pkg::IDX_W-1:0]] = '{data: 8'd0, kind: jsu_pkg::KIND_UNTERM};
            cnt     = cnt + 3'd1;
            st_next = jsu_pkg::DEC_STATE_RESET;
        end

        res_cnt = cnt;
    end

endmodule

### design/json_string_unescape.sv
// An accepted input transaction is registered in the input stage, then decoded into the result buffer.
// Throughput: one input transaction per cycle while each byte yields at most one result
// and m_axis_tready stays high; an item that yields N results (up to 4, e.g. a 3-byte
// UTF-8 code) holds the result buffer, and so the input, until its results are taken.
// Reset (rst_n low, asynchronous): decoder back to normal mode, input and result
// stages emptied.
module json_string_unescape
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // in_last

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    output logic       m_axis_tlast    // last_of_run
);

    logic                      in_valid_reg;
    logic [7:0]                in_byte_reg;
    logic                      in_last_reg;

    jsu_pkg::dec_state_t       st_reg;
    jsu_pkg::dec_state_t       st_next;
    logic [7:0]                pend_reg [jsu_pkg::PEND_DEPTH];
    jsu_pkg::pend_wr_t         pend_wr;

    jsu_pkg::result_t          res_next [jsu_pkg::MAX_RESULTS];
    logic [jsu_pkg::CNT_W-1:0] res_cnt_next;
    jsu_pkg::result_t          res_reg  [jsu_pkg::MAX_RESULTS];
    logic [jsu_pkg::CNT_W-1:0] rem_reg;
    logic [jsu_pkg::IDX_W-1:0] idx_reg;

    logic                      out_fire;
    logic                      buf_free;
    logic                      advance;

    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign buf_free      = (rem_reg == '0) || (rem_reg == 3'd1 && m_axis_tready);
    assign advance       = in_valid_reg && buf_free;
    assign s_axis_tready = !in_valid_reg || advance;

    jsu_decode u_decode
    (
        .st      (st_reg),
        .pend    (pend_reg),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .st_next (st_next),
        .pend_wr (pend_wr),
        .res     (res_next),
        .res_cnt (res_cnt_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            st_reg       <= jsu_pkg::DEC_STATE_RESET;
            rem_reg      <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
            begin
                st_reg  <= st_next;
                rem_reg <= res_cnt_next;
                idx_reg <= '0;
            end
            else if (out_fire)
            begin
                rem_reg <= rem_reg - 3'd1;
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance)
        begin
            res_reg <= res_next;
            if (pend_wr.we)
                pend_reg[pend_wr.idx] <= pend_wr.data;
        end
    end

    assign m_axis_tvalid = (rem_reg != '0);
    assign m_axis_tdata  = res_reg[idx_reg].data;
    assign m_axis_tuser  = res_reg[idx_reg].kind;
    assign m_axis_tlast  = (rem_reg == 3'd1);

endmodule

### test/tb_top.sv
module tb_top;

    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } unesc_res_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast = 1'b0;    // in_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic [1:0] m_axis_tuser;           // [1:0] kind
    logic       m_axis_tlast;           // last_of_run

    // expected decoder output, oldest first
    unesc_res_t  expected_bytes[$];
    int          errors = 0;
    int          items_sent = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles = 0;

    // shadow decoder state
    jsu_pkg::mode_t dec_mode;
    logic [1:0]  hex_cnt;
    logic [15:0] code_acc;
    logic        hex_stop;
    logic [7:0]  held_chars[3];

    json_string_unescape dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return 8'("0") + 8'(v);
        if ($urandom_range(1))
            return 8'("A") + 8'(v) - 8'd10;
        return 8'("a") + 8'(v) - 8'd10;
    endfunction

    function automatic bit end_flag_roll();
        return $urandom_range(39) == 0;
    endfunction

    function automatic void clear_decoder();
        dec_mode = jsu_pkg::MODE_NORMAL;
        hex_cnt  = 2'd0;
        code_acc = 16'd0;
        hex_stop = 1'b0;
    endfunction

    function automatic void emit(ref unesc_res_t run[$], input logic [7:0] d,
                                 input logic [1:0] k);
        run.push_back('{data: d, kind: k, last: 1'b0});
    endfunction

    // Advance the shadow decoder by one accepted byte and queue what it yields.
    function automatic void predict_unescape(input logic [7:0] b, input logic l);
        unesc_res_t run[$];
        int         d;
        bit         closed;
        closed = 0;
        case (dec_mode)
            jsu_pkg::MODE_ESCAPE:
            begin
                dec_mode = jsu_pkg::MODE_NORMAL;
                if (b == jsu_pkg::CH_N)
                    emit(run, jsu_pkg::CH_LF, jsu_pkg::KIND_DATA);
                else if (b == jsu_pkg::CH_T)
                    emit(run, jsu_pkg::CH_TAB, jsu_pkg::KIND_DATA);
                else if (b == jsu_pkg::CH_R)
                    emit(run, jsu_pkg::CH_CR, jsu_pkg::KIND_DATA);
                else if (b == jsu_pkg::CH_U)
                begin
                    dec_mode = jsu_pkg::MODE_HEX;
                    hex_cnt  = 2'd0;
                    code_acc = 16'd0;
                    hex_stop = 1'b0;
                end
                else
                    emit(run, b, jsu_pkg::KIND_DATA);
            end
            jsu_pkg::MODE_HEX:
            begin
                d = hex_value(b);
                if (!hex_stop && d >= 0)
                    code_acc = {code_acc[11:0], 4'(d)};
                else
                    hex_stop = 1'b1;
                if (hex_cnt == 2'd3)
                begin
                    if (code_acc < 16'h0080)
                        emit(run, code_acc[7:0], jsu_pkg::KIND_DATA);
                    else if (code_acc < 16'h0800)
                    begin
                        emit(run, 8'hC0 | 8'(code_acc >> 6), jsu_pkg::KIND_DATA);
                        emit(run, 8'h80 | 8'(code_acc[5:0]), jsu_pkg::KIND_DATA);
                    end
                    else
                    begin
                        emit(run, 8'hE0 | 8'(code_acc >> 12), jsu_pkg::KIND_DATA);
                        emit(run, 8'h80 | 8'(code_acc[11:6]), jsu_pkg::KIND_DATA);
                        emit(run, 8'h80 | 8'(code_acc[5:0]), jsu_pkg::KIND_DATA);
                    end
                    dec_mode = jsu_pkg::MODE_NORMAL;
                    hex_cnt  = 2'd0;
                end
                else if (l)
                begin
                    // short escape cut off by end of input: replay raw chars
                    for (int i = 0; i < int'(hex_cnt); i++)
                        emit(run, held_chars[i], jsu_pkg::KIND_DATA);
                    emit(run, b, jsu_pkg::KIND_DATA);
                end
                else
                begin
                    held_chars[hex_cnt] = b;
                    hex_cnt = hex_cnt + 2'd1;
                end
            end
            default:
            begin
                if (b == jsu_pkg::CH_QUOTE)
                begin
                    emit(run, 8'h00, jsu_pkg::KIND_CLOSED);
                    closed = 1;
                end
                else if (b == jsu_pkg::CH_BSLASH)
                    dec_mode = jsu_pkg::MODE_ESCAPE;
                else
                    emit(run, b, jsu_pkg::KIND_DATA);
            end
        endcase
        if (closed)
            clear_decoder();
        else if (l)
        begin
            emit(run, 8'h00, jsu_pkg::KIND_UNTERM);
            clear_decoder();
        end
        if (run.size() > 0)
            run[run.size() - 1].last = 1'b1;
        foreach (run[i])
            expected_bytes.push_back(run[i]);
    endfunction

    // Call at a rising edge; returns at the edge that accepts the transaction.
    task automatic send_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_unescape(b, l);
        items_sent++;
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_bytes.size() > 0);
    endtask

    task automatic test_plain_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_simple_escapes();
        send_byte(jsu_pkg::CH_BSLASH, 1'b0);
        send_byte(jsu_pkg::CH_QUOTE, 1'b0);
        send_byte(jsu_pkg::CH_BSLASH, 1'b0);
        send_byte(jsu_pkg::CH_N, 1'b0);
        send_byte(jsu_pkg::CH_BSLASH, 1'b0);
        send_byte("b", 1'b0);
    endtask

    task automatic test_unicode_zero();
        send_byte(jsu_pkg::CH_BSLASH, 1'b0);
        send_byte(jsu_pkg::CH_U, 1'b0);
        repeat (4)
            send_byte("0", 1'b0);
    endtask

    task automatic test_end_of_input();
        // escaped backslash as final byte
        send_byte(jsu_pkg::CH_BSLASH, 1'b0);
        send_byte(jsu_pkg::CH_BSLASH, 1'b1);
        // escape letter u as final byte
        send_byte(jsu_pkg::CH_BSLASH, 1'b0);
        send_byte(jsu_pkg::CH_U, 1'b1);
        // short \u cut off
        send_byte(jsu_pkg::CH_BSLASH, 1'b0);
        send_byte(jsu_pkg::CH_U, 1'b0);
        send_byte("A", 1'b0);
        send_byte("q", 1'b1);
        // quote collected as non-hex, fourth byte flagged last
        send_byte(jsu_pkg::CH_BSLASH, 1'b0);
        send_byte(jsu_pkg::CH_U, 1'b0);
        send_byte(jsu_pkg::CH_QUOTE, 1'b0);
        send_byte("1", 1'b0);
        send_byte("2", 1'b0);
        send_byte("F", 1'b1);
        // closing quote flagged last
        send_byte(jsu_pkg::CH_QUOTE, 1'b1);
        send_byte(jsu_pkg::CH_QUOTE, 1'b0);
    endtask

    task automatic send_random_token();
        int          pick;
        logic [15:0] cp;
        logic [7:0]  c;
        logic [7:0]  digits[4];
        int          n_chars;
        pick = $urandom_range(99);
        if (pick < 35)
            send_byte(8'($urandom_range(255)), end_flag_roll());
        else if (pick < 55)
        begin
            send_byte(jsu_pkg::CH_BSLASH, end_flag_roll());
            case ($urandom_range(9))
                0: c = jsu_pkg::CH_QUOTE;
                1: c = jsu_pkg::CH_BSLASH;
                2: c = "/";
                3: c = jsu_pkg::CH_N;
                4: c = jsu_pkg::CH_T;
                5: c = jsu_pkg::CH_R;
                6: c = "b";
                7: c = "f";
                default: c = 8'($urandom_range(255));
            endcase
            send_byte(c, end_flag_roll());
        end
        else if (pick < 88)
        begin
            case ($urandom_range(2))
                0: cp = 16'($urandom_range(16'h007F));
                1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
                default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
            endcase
            for (int i = 0; i < 4; i++)
                digits[i] = hex_char(cp[15 - 4*i -: 4]);
            if ($urandom_range(4) == 0)
            begin
                do
                    c = 8'($urandom_range(255));
                while (hex_value(c) >= 0);
                digits[$urandom_range(3)] = c;
            end
            // mostly complete escapes, now and then a truncated one
            n_chars = ($urandom_range(9) == 0) ? $urandom_range(3) : 4;
            send_byte(jsu_pkg::CH_BSLASH, end_flag_roll());
            send_byte(jsu_pkg::CH_U, end_flag_roll());
            for (int i = 0; i < n_chars; i++)
                send_byte(digits[i], end_flag_roll());
        end
        else
            send_byte(jsu_pkg::CH_QUOTE, end_flag_roll());
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int n_items);
        int stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = items_sent + n_items / 2;
        while (items_sent < stop_at)
            send_random_token();
        // hold off until the output side has caught up
        wait_results_drained();
        stop_at = items_sent + n_items - n_items / 2;
        while (items_sent < stop_at)
            send_random_token();
        wait_results_drained();
    endtask

    always @(posedge clk)
    begin : result_check
        unesc_res_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected result transaction: out_byte %h kind %0d last %0b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end
            else
            begin
                exp_r = expected_bytes.pop_front();
                if (m_axis_tdata !== exp_r.data)
                begin
                    $error("out_byte: expected %h, actual %h", exp_r.data, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== exp_r.kind)
                begin
                    $error("kind: expected %0d, actual %0d", exp_r.kind, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== exp_r.last)
                begin
                    $error("last_of_run: expected %0b, actual %0b", exp_r.last,
                           m_axis_tlast);
                    errors++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        clear_decoder();
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_bytes();
        test_simple_escapes();
        test_unicode_zero();
        test_end_of_input();
        wait_results_drained();

        test_random_phase(0, 0, 105);
        test_random_phase(77, 0, 105);
        test_random_phase(0, 77, 105);
        test_random_phase(37, 37, 105);

        repeat (8)
            @(posedge clk);
        if (errors == 0 && expected_bytes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
design/jsu_pkg.sv
design/jsu_decode.sv
design/json_string_unescape.sv
test/tb_top.sv
